// ===== rtl/swcc_pkg.sv =====
`timescale 1ns / 1ps
package swcc_pkg;

  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  localparam logic [1:0] MODE_FWD  = 2'd0;
  localparam logic [1:0] MODE_REV  = 2'd1;
  localparam logic [1:0] MODE_BOTH = 2'd2;

  // Register index, taken from paddr[2]
  localparam logic REG_IDX_MODE = 1'b0;

  localparam int FIELD_ID_W = 6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_FWD_RD,
    ST_FWD_WAIT,
    ST_FWD_WR,
    ST_REV_RD,
    ST_REV_WAIT,
    ST_REV_WR,
    ST_RD_ADDR,
    ST_RD_WAIT,
    ST_OUT
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic push;
    logic clr_start;
    logic walk_start;
    logic walk_rev;
    logic walk_step;
    logic mem_rd;
    logic mem_wr;
    logic rd_req;
    logic out_load;
    logic out_take;
  } swcc_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic clr_done;
    logic walk_full;
    logic walk_hit;
    logic walk_last;
    logic out_full;
  } swcc_sts_t;

endpackage

// ===== rtl/sliding_window_cooccurrence_counter.sv =====
`timescale 1ns / 1ps
// Weighted co-occurrence counter over a sliding token window. A push shifts
// one token into the window; once the chunk has filled the window, each
// enabled direction walks it slot by slot, going through read, wait and
// write on the count memory for each in-vocabulary context word and then
// handing over. A read passes through address, wait and output states;
// its result waits in the output register without holding up later items,
// but the next read waits until that result is taken. A clear, and reset,
// sweep every count memory entry (2^(2*VW), VW = clog2(VOCAB_SIZE) but at
// least 1; 4096 at the default size) one per cycle, during which no item
// is taken.
module sliding_window_cooccurrence_counter #(
  parameter int VOCAB_SIZE = 64,
  parameter int WINDOW_LEN = 11,
  parameter int COUNT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [5:0]  in_token_id,
  input  logic        in_in_vocab,
  input  logic        in_first_of_chunk,
  input  logic [5:0]  in_read_row,
  input  logic [5:0]  in_read_col,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_pair_count,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import swcc_pkg::*;

  logic [1:0] mode_r;
  swcc_cmd_t  cmd;
  swcc_sts_t  sts;
  logic       win_full_nxt;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_IDX_MODE) ? {30'd0, mode_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_BOTH;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == REG_IDX_MODE) begin
      mode_r <= cfg_pwdata[1:0];
    end
  end

  swcc_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_action    (in_action),
    .out_stall    (out_stall),
    .mode         (mode_r),
    .win_full_nxt (win_full_nxt),
    .cmd          (cmd),
    .sts          (sts)
  );

  swcc_dp #(
    .VOCAB_SIZE (VOCAB_SIZE),
    .WINDOW_LEN (WINDOW_LEN),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_first_of_chunk (in_first_of_chunk),
    .in_token_id       (in_token_id),
    .in_in_vocab       (in_in_vocab),
    .in_read_row       (in_read_row),
    .in_read_col       (in_read_col),
    .win_full_nxt      (win_full_nxt),
    .out_valid         (out_valid),
    .out_pair_count    (out_pair_count),
    .cmd               (cmd),
    .sts               (sts)
  );
endmodule

// ===== rtl/swcc_ram.sv =====
`timescale 1ns / 1ps
module swcc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end
endmodule

// ===== rtl/swcc_ctrl.sv =====
`timescale 1ns / 1ps
module swcc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_action,
  input  logic                 out_stall,
  input  logic [1:0]           mode,
  input  logic                 win_full_nxt,
  output swcc_pkg::swcc_cmd_t  cmd,
  input  swcc_pkg::swcc_sts_t  sts
);
  import swcc_pkg::*;

  state_t state_r, state_nxt;
  logic   acc;
  logic   do_fwd, do_rev;
  logic   out_free;

  assign do_fwd = (mode != MODE_REV);
  assign do_rev = (mode != MODE_FWD);
  assign in_stall = (state_r != ST_IDLE);
  assign acc = in_valid && !in_stall;
  // the output register is free, or its transfer happens at this edge
  assign out_free = !sts.out_full || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          case (in_action)
            ACT_PUSH: begin
              if (win_full_nxt && do_fwd) state_nxt = ST_FWD_RD;
              else if (win_full_nxt && do_rev) state_nxt = ST_REV_RD;
            end
            ACT_READ:  state_nxt = ST_RD_ADDR;
            ACT_CLEAR: state_nxt = ST_CLEAR;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR: if (sts.clr_done) state_nxt = ST_IDLE;
      ST_FWD_RD: begin
        if (!sts.walk_full || sts.walk_last) state_nxt = do_rev ? ST_REV_RD : ST_IDLE;
        else if (sts.walk_hit) state_nxt = ST_FWD_WAIT;
      end
      ST_FWD_WAIT: state_nxt = ST_FWD_WR;
      ST_FWD_WR:   state_nxt = ST_FWD_RD;
      ST_REV_RD: begin
        if (!sts.walk_full || sts.walk_last) state_nxt = ST_IDLE;
        else if (sts.walk_hit) state_nxt = ST_REV_WAIT;
      end
      ST_REV_WAIT: state_nxt = ST_REV_WR;
      ST_REV_WR:   state_nxt = ST_REV_RD;
      ST_RD_ADDR:  state_nxt = ST_RD_WAIT;
      ST_RD_WAIT:  state_nxt = ST_OUT;
      ST_OUT:      if (out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.out_take = !out_stall;
    case (state_r)
      ST_IDLE: begin
        cmd.push = acc && (in_action == ACT_PUSH);
        cmd.rd_req = acc && (in_action == ACT_READ);
        cmd.clr_start = acc && (in_action == ACT_CLEAR);
        cmd.walk_start = cmd.push && win_full_nxt;
        cmd.walk_rev = !do_fwd;
      end
      ST_FWD_RD, ST_REV_RD: begin
        // skip unknown slots one per cycle; at the last slot hand over
        cmd.mem_rd = sts.walk_full && sts.walk_hit && !sts.walk_last;
        cmd.walk_step = sts.walk_full && !sts.walk_hit && !sts.walk_last;
        cmd.walk_start = (state_r == ST_FWD_RD) && do_rev &&
                         (!sts.walk_full || sts.walk_last);
        cmd.walk_rev = 1'b1;
      end
      ST_FWD_WR, ST_REV_WR: begin
        cmd.mem_wr = 1'b1;
        cmd.walk_step = 1'b1;
      end
      ST_OUT: cmd.out_load = out_free;
      default: ;
    endcase
  end
endmodule

// ===== rtl/swcc_dp.sv =====
`timescale 1ns / 1ps
module swcc_dp #(
  parameter int VOCAB_SIZE = 64,
  parameter int WINDOW_LEN = 11,
  parameter int COUNT_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_first_of_chunk,
  input  logic [swcc_pkg::FIELD_ID_W-1:0]      in_token_id,
  input  logic                                 in_in_vocab,
  input  logic [swcc_pkg::FIELD_ID_W-1:0]      in_read_row,
  input  logic [swcc_pkg::FIELD_ID_W-1:0]      in_read_col,
  output logic                                 win_full_nxt,
  output logic                                 out_valid,
  output logic [31:0]                          out_pair_count,
  input  swcc_pkg::swcc_cmd_t                  cmd,
  output swcc_pkg::swcc_sts_t                  sts
);
  import swcc_pkg::*;

  localparam int VW = (VOCAB_SIZE > 1) ? $clog2(VOCAB_SIZE) : 1;
  // row and column each take VW address bits
  localparam int AW = 2 * VW;
  localparam int DEPTH = 1 << AW;
  localparam int PW = $clog2(WINDOW_LEN);
  localparam int FW = $clog2(WINDOW_LEN + 1);
  localparam int IW = ((VW > FIELD_ID_W) ? VW : FIELD_ID_W) + 1;
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  logic [VW-1:0] ids_r [WINDOW_LEN];
  logic          known_r [WINDOW_LEN];
  logic [FW-1:0] fill_r, fill_base;
  logic          tok_known;
  logic [IW-1:0] tok_ext, row_ext, col_ext;

  // walk state
  logic [PW-1:0] pos_r;
  logic [PW-1:0] k_r;
  logic          rev_r;
  logic [VW-1:0] center_r;
  logic          walk_full_r;
  logic [AW-1:0] waddr_r;
  logic [COUNT_BITS-1:0] wdata;

  logic [AW-1:0] clr_r;
  logic          clr_on_r;
  logic [AW-1:0] raddr;
  logic [COUNT_BITS-1:0] rdata;
  logic          rd_ok_r;
  logic [COUNT_BITS-1:0] weight;

  assign tok_ext = IW'(in_token_id);
  assign row_ext = IW'(in_read_row);
  assign col_ext = IW'(in_read_col);
  assign tok_known = in_in_vocab && (tok_ext < IW'(VOCAB_SIZE));
  assign fill_base = in_first_of_chunk ? '0 : fill_r;
  assign win_full_nxt = (fill_base >= FW'(WINDOW_LEN - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        ids_r[i] <= '0;
        known_r[i] <= 1'b0;
      end
    end else if (cmd.push) begin
      for (int i = 0; i + 1 < WINDOW_LEN; i++) begin
        ids_r[i] <= ids_r[i + 1];
        known_r[i] <= known_r[i + 1];
      end
      ids_r[WINDOW_LEN - 1] <= tok_known ? VW'(tok_ext) : '0;
      known_r[WINDOW_LEN - 1] <= tok_known;
      if (fill_base < FW'(WINDOW_LEN)) fill_r <= fill_base + FW'(1);
      else fill_r <= fill_base;
    end
  end

  // Walk: walk_full_r marks a live walk; the centre is read on the first step.
  logic          cur_known;
  logic [VW-1:0] cur_id;
  logic          at_last;
  assign cur_known = known_r[pos_r];
  assign cur_id = ids_r[pos_r];
  assign at_last = rev_r ? (pos_r == '0) : (pos_r == PW'(WINDOW_LEN - 1));

  // The centre slot is processed at k=0: if unknown the walk ends.
  assign sts.walk_full = walk_full_r;
  assign sts.walk_hit = cur_known && (k_r != '0);
  assign sts.walk_last = at_last && !(cur_known && k_r != '0);
  assign sts.clr_done = clr_on_r && (clr_r == AW'(DEPTH - 1));
  assign sts.out_full = out_valid;

  // A bare step past the centre or an unknown slot, and the final step after a
  // hit, both land here; walk_step on the last slot ends the walk.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_full_r <= 1'b0;
      pos_r <= '0;
      k_r <= '0;
      rev_r <= 1'b0;
      center_r <= '0;
    end else if (cmd.walk_start) begin
      // the centre is known only after the push lands, so load lazily
      rev_r <= cmd.walk_rev;
      pos_r <= cmd.walk_rev ? PW'(WINDOW_LEN - 1) : '0;
      k_r <= '0;
      walk_full_r <= 1'b1;
    end else if (walk_full_r && k_r == '0) begin
      // centre slot
      if (!cur_known) begin
        walk_full_r <= 1'b0;
      end else begin
        center_r <= cur_id;
        k_r <= PW'(1);
        pos_r <= rev_r ? pos_r - PW'(1) : pos_r + PW'(1);
      end
    end else if (cmd.walk_step) begin
      if (cur_known) k_r <= k_r + PW'(1);
      if (at_last) walk_full_r <= 1'b0;
      else pos_r <= rev_r ? pos_r - PW'(1) : pos_r + PW'(1);
    end else if (walk_full_r && at_last && !cur_known) begin
      walk_full_r <= 1'b0;
    end
  end

  assign weight = COUNT_BITS'(WINDOW_LEN) - COUNT_BITS'(k_r);
  assign wdata = clr_on_r ? '0 :
                 ((CMAX - rdata) < weight) ? CMAX : rdata + weight;

  always_ff @(posedge clk) begin
    if (cmd.mem_rd) waddr_r <= AW'({center_r, cur_id});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_on_r <= 1'b1;
      clr_r <= '0;
    end else if (cmd.clr_start) begin
      clr_on_r <= 1'b1;
      clr_r <= '0;
    end else if (clr_on_r) begin
      if (clr_r == AW'(DEPTH - 1)) clr_on_r <= 1'b0;
      clr_r <= clr_r + AW'(1);
    end
  end

  logic [AW-1:0] rd_addr_r;
  always_ff @(posedge clk) begin
    if (cmd.rd_req) begin
      rd_addr_r <= AW'({VW'(row_ext), VW'(col_ext)});
      rd_ok_r <= (row_ext < IW'(VOCAB_SIZE)) && (col_ext < IW'(VOCAB_SIZE));
    end
  end

  // hold the pair address through wait and write so the read data stays put
  assign raddr = cmd.mem_rd ? AW'({center_r, cur_id}) :
                 walk_full_r ? waddr_r : rd_addr_r;

  swcc_ram #(.WIDTH(COUNT_BITS), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (cmd.mem_wr || clr_on_r),
    .waddr (clr_on_r ? clr_r : waddr_r),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  logic [31:0] sat32;
  always_comb begin
    if (COUNT_BITS > 32) begin
      sat32 = (rdata > COUNT_BITS'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : 32'(rdata);
    end else begin
      sat32 = 32'(rdata);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (cmd.out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_pair_count <= rd_ok_r ? sat32 : '0;
  end
endmodule
